FILE: design/char_lcd_nibble_sequencer_assert.svh
// Assertion macros for the character LCD nibble sequencer checker.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define LCDSEQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define LCDSEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lcdseq_pkg.sv
// Shared types, op codes and command encodings of the LCD nibble sequencer.
package lcdseq_pkg;

	localparam logic [3:0] OP_CMD      = 4'd0;
	localparam logic [3:0] OP_CHAR     = 4'd1;
	localparam logic [3:0] OP_NIBBLE   = 4'd2;
	localparam logic [3:0] OP_CLEAR    = 4'd3;
	localparam logic [3:0] OP_HOME     = 4'd4;
	localparam logic [3:0] OP_DISPLAY  = 4'd5;
	localparam logic [3:0] OP_CURSOR   = 4'd6;
	localparam logic [3:0] OP_BLINK    = 4'd7;
	localparam logic [3:0] OP_POSITION = 4'd8;
	localparam logic [3:0] OP_BACKLT   = 4'd9;

	localparam logic [2:0] PIN_RS = 3'd0;
	localparam logic [2:0] PIN_EN = 3'd2;
	localparam logic [2:0] PIN_BL = 3'd3;
	localparam logic [2:0] PIN_D7 = 3'd7;

	localparam logic [4:0] COL_MAX = 5'd16;
	localparam logic [1:0] ROW_MAX = 2'd2;

	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_DISPCTL = 8'h08;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;

	localparam logic [15:0] WAIT_US_EN   = 16'd50;
	localparam logic [15:0] WAIT_US_CMD  = 16'd2050;
	localparam logic [15:0] WAIT_US_HOME = 16'd7050;
	localparam logic [15:0] WAIT_US_NIB  = 16'd35050;

	typedef struct packed {
		logic [3:0] op;
		logic [7:0] value;
		logic       flag;
		logic [4:0] column;
		logic [1:0] row;
	} item_t;

	typedef struct packed {
		logic [7:0]  port_byte;
		logic [15:0] wait_us;
		logic        last;
	} beat_t;

	typedef enum logic [1:0] {
		LVL_ZERO,
		LVL_ONE,
		LVL_DATA,
		LVL_FLAG
	} level_sel_t;

	typedef enum logic [2:0] {
		WT_NONE,
		WT_EN,
		WT_CMD,
		WT_HOME,
		WT_NIB
	} wait_sel_t;

	typedef struct packed {
		logic       load;
		logic       reload;
		logic       emit;
		logic [2:0] pin;
		level_sel_t level;
		logic       nib_hi;
		wait_sel_t  wait_sel;
		logic       last;
	} cmd_t;

endpackage

FILE: design/lcdseq_dp.sv
// Datapath: port shadow, control bits, byte to send and the output beat register.
module lcdseq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdseq_pkg::item_t   item,
	input  lcdseq_pkg::cmd_t    cmd,
	output logic                out_free,
	output logic                pin_wr_valid,
	input  logic                pin_wr_ready,
	output lcdseq_pkg::beat_t   pin_wr
);

	logic [7:0]         shadow_q;
	logic [2:0]         ctrl_q;
	logic [7:0]         byte_q;
	logic               flag_q;
	logic               valid_q;
	lcdseq_pkg::beat_t  beat_q;

	logic [3:0]  nib;
	logic        level;
	logic [7:0]  port_next;
	logic [15:0] wait_val;
	logic [2:0]  mask;
	logic [2:0]  ctrl_new;
	logic [7:0]  row_base;
	logic [7:0]  load_byte;

	assign nib      = cmd.nib_hi ? byte_q[7:4] : byte_q[3:0];
	assign out_free = !valid_q || pin_wr_ready;

	always_comb begin
		case (cmd.level)
			lcdseq_pkg::LVL_ZERO: level = 1'b0;
			lcdseq_pkg::LVL_ONE:  level = 1'b1;
			lcdseq_pkg::LVL_DATA: level = nib[cmd.pin[1:0]];
			lcdseq_pkg::LVL_FLAG: level = flag_q;
			default:              level = 1'b0;
		endcase
		port_next = shadow_q;
		port_next[cmd.pin] = level;
	end

	always_comb begin
		case (cmd.wait_sel)
			lcdseq_pkg::WT_NONE: wait_val = '0;
			lcdseq_pkg::WT_EN:   wait_val = lcdseq_pkg::WAIT_US_EN;
			lcdseq_pkg::WT_CMD:  wait_val = lcdseq_pkg::WAIT_US_CMD;
			lcdseq_pkg::WT_HOME: wait_val = lcdseq_pkg::WAIT_US_HOME;
			lcdseq_pkg::WT_NIB:  wait_val = lcdseq_pkg::WAIT_US_NIB;
			default:             wait_val = '0;
		endcase
	end

	always_comb begin
		case (item.op)
			lcdseq_pkg::OP_DISPLAY: mask = 3'b100;
			lcdseq_pkg::OP_CURSOR:  mask = 3'b010;
			lcdseq_pkg::OP_BLINK:   mask = 3'b001;
			default:                mask = 3'b000;
		endcase
		ctrl_new = item.flag ? (ctrl_q | mask) : (ctrl_q & ~mask);
		case (item.row)
			2'd0:    row_base = 8'h00;
			2'd1:    row_base = 8'h40;
			2'd2:    row_base = 8'h14;
			default: row_base = 8'h54;
		endcase
		case (item.op)
			lcdseq_pkg::OP_NIBBLE:   load_byte = {4'd0, item.value[3:0]};
			lcdseq_pkg::OP_CLEAR:    load_byte = lcdseq_pkg::CMD_CLEAR;
			lcdseq_pkg::OP_HOME:     load_byte = lcdseq_pkg::CMD_HOME;
			lcdseq_pkg::OP_DISPLAY,
			lcdseq_pkg::OP_CURSOR,
			lcdseq_pkg::OP_BLINK:    load_byte = lcdseq_pkg::CMD_DISPCTL | {5'd0, ctrl_new};
			lcdseq_pkg::OP_POSITION: load_byte = (lcdseq_pkg::CMD_DDRAM | row_base)
				+ {3'd0, item.column};
			default:                 load_byte = item.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= '0;
			ctrl_q   <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				ctrl_q <= ctrl_new;
			end
			if (cmd.emit) begin
				shadow_q <= port_next;
				valid_q  <= 1'b1;
			end else if (pin_wr_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= load_byte;
			flag_q <= item.flag;
		end else if (cmd.reload) begin
			byte_q <= lcdseq_pkg::CMD_HOME;
		end
		if (cmd.emit) begin
			beat_q.port_byte <= port_next;
			beat_q.wait_us   <= wait_val;
			beat_q.last      <= cmd.last;
		end
	end

	assign pin_wr_valid = valid_q;
	assign pin_wr       = beat_q;

endmodule

FILE: design/lcdseq_ctrl.sv
// Controller: steps each op through its run of single-pin writes.
module lcdseq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  lcdseq_pkg::item_t  item,
	input  logic               out_free,
	output lcdseq_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_RS,
		S_HI,
		S_LO,
		S_BL
	} state_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_CMD,
		K_CHAR,
		K_NIB,
		K_CLEAR,
		K_HOME,
		K_BL
	} kind_t;

	state_t     state_q;
	kind_t      kind_q;
	logic [2:0] step_q;
	logic       second_q;

	kind_t      kind_in;
	logic       accept;
	logic       pos_ok;
	logic       clear_first;

	assign item_ready  = (state_q == S_IDLE);
	assign accept      = item_valid && item_ready;
	assign pos_ok      = (item.column <= lcdseq_pkg::COL_MAX) && (item.row <= lcdseq_pkg::ROW_MAX);
	assign clear_first = (kind_q == K_CLEAR) && !second_q;

	always_comb begin
		case (item.op)
			lcdseq_pkg::OP_CMD,
			lcdseq_pkg::OP_DISPLAY,
			lcdseq_pkg::OP_CURSOR,
			lcdseq_pkg::OP_BLINK:    kind_in = K_CMD;
			lcdseq_pkg::OP_POSITION: kind_in = pos_ok ? K_CMD : K_NONE;
			lcdseq_pkg::OP_CHAR:     kind_in = K_CHAR;
			lcdseq_pkg::OP_NIBBLE:   kind_in = K_NIB;
			lcdseq_pkg::OP_CLEAR:    kind_in = K_CLEAR;
			lcdseq_pkg::OP_HOME:     kind_in = K_HOME;
			lcdseq_pkg::OP_BACKLT:   kind_in = K_BL;
			default:                 kind_in = K_NONE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.level    = lcdseq_pkg::LVL_ZERO;
		cmd.wait_sel = lcdseq_pkg::WT_NONE;
		cmd.nib_hi   = (state_q == S_HI);
		case (state_q)
			S_SETUP: begin
				cmd.emit = out_free;
				cmd.pin  = step_q;
			end
			S_RS: begin
				cmd.emit  = out_free;
				cmd.pin   = lcdseq_pkg::PIN_RS;
				cmd.level = lcdseq_pkg::LVL_ONE;
			end
			S_HI, S_LO: begin
				cmd.emit = out_free;
				if (step_q <= 3'd3) begin
					cmd.pin   = lcdseq_pkg::PIN_D7 - step_q;
					cmd.level = lcdseq_pkg::LVL_DATA;
				end else if (step_q == 3'd4) begin
					cmd.pin      = lcdseq_pkg::PIN_EN;
					cmd.level    = lcdseq_pkg::LVL_ONE;
					cmd.wait_sel = lcdseq_pkg::WT_EN;
				end else begin
					cmd.pin      = lcdseq_pkg::PIN_EN;
					cmd.wait_sel = lcdseq_pkg::WT_EN;
					if (state_q == S_LO) begin
						cmd.last   = !clear_first;
						cmd.reload = clear_first && out_free;
						case (kind_q)
							K_CMD:   cmd.wait_sel = lcdseq_pkg::WT_CMD;
							K_NIB:   cmd.wait_sel = lcdseq_pkg::WT_NIB;
							K_HOME:  cmd.wait_sel = lcdseq_pkg::WT_HOME;
							K_CLEAR: cmd.wait_sel = second_q ? lcdseq_pkg::WT_HOME
								: lcdseq_pkg::WT_CMD;
							default: cmd.wait_sel = lcdseq_pkg::WT_EN;
						endcase
					end
				end
			end
			S_BL: begin
				cmd.emit  = out_free;
				cmd.pin   = lcdseq_pkg::PIN_BL;
				cmd.level = lcdseq_pkg::LVL_FLAG;
				cmd.last  = 1'b1;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kind_q   <= K_NONE;
			step_q   <= '0;
			second_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q   <= kind_in;
						step_q   <= '0;
						second_q <= 1'b0;
						case (kind_in)
							K_CMD, K_NIB, K_CLEAR, K_HOME: state_q <= S_SETUP;
							K_CHAR:                        state_q <= S_RS;
							K_BL:                          state_q <= S_BL;
							default:                       state_q <= S_IDLE;
						endcase
					end
				end
				S_SETUP: begin
					if (out_free) begin
						if (step_q == 3'd2) begin
							step_q  <= '0;
							state_q <= (kind_q == K_NIB) ? S_LO : S_HI;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				S_RS: begin
					if (out_free) begin
						state_q <= S_HI;
					end
				end
				S_HI, S_LO: begin
					if (out_free) begin
						if (step_q == 3'd5) begin
							step_q <= '0;
							if (state_q == S_HI) begin
								state_q <= S_LO;
							end else if (clear_first) begin
								second_q <= 1'b1;
								state_q  <= S_SETUP;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				S_BL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit sequencer: controller plus datapath.
// The first port write beat is registered from the state that the controller enters on taking the op beat.
// Throughput: one port write per cycle while the output beat register is free to take it.
// The controller walks one op at a time; the next op is taken once its last write is staged.
// Rejected positions and unused op codes are taken in idle and give no beats.
// Reset clears the port shadow and the display control bits to zero.
module char_lcd_nibble_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  lcdseq_pkg::item_t  item,
	output logic               pin_wr_valid,
	input  logic               pin_wr_ready,
	output lcdseq_pkg::beat_t  pin_wr
);

	lcdseq_pkg::cmd_t cmd;
	logic             out_free;

	lcdseq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_free   (out_free),
		.cmd        (cmd)
	);

	lcdseq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.out_free     (out_free),
		.pin_wr_valid (pin_wr_valid),
		.pin_wr_ready (pin_wr_ready),
		.pin_wr       (pin_wr)
	);

endmodule

FILE: design/lcdseq_checker.sv
// Port-level checker for the LCD nibble sequencer and its bind.
`include "char_lcd_nibble_sequencer_assert.svh"

module lcdseq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input lcdseq_pkg::item_t  item,
	input logic               pin_wr_valid,
	input logic               pin_wr_ready,
	input lcdseq_pkg::beat_t  pin_wr
);

	logic wait_ok;

	assign wait_ok = (pin_wr.wait_us == 16'd0) || (pin_wr.wait_us == 16'd50)
		|| (pin_wr.wait_us == 16'd2050) || (pin_wr.wait_us == 16'd7050)
		|| (pin_wr.wait_us == 16'd35050);

	`LCDSEQ_ASSERT_NEXT(a_beat_hold, clk, arst_n, pin_wr_valid && !pin_wr_ready, pin_wr_valid && $stable(pin_wr), "stalled beat changed")
	`LCDSEQ_ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && !item_ready, item_valid && $stable(item), "waiting op beat changed")
	`LCDSEQ_ASSERT_NOW(a_busy_midop, clk, arst_n, pin_wr_valid && !pin_wr.last, !item_ready, "op taken before previous op finished")
	`LCDSEQ_ASSERT_NOW(a_en_high_wait, clk, arst_n, pin_wr_valid && pin_wr.port_byte[2], pin_wr.wait_us == 16'd50, "enable high write without 50 us wait")
	`LCDSEQ_ASSERT_NOW(a_wait_legal, clk, arst_n, pin_wr_valid, wait_ok, "illegal wait value")

endmodule

bind char_lcd_nibble_sequencer lcdseq_checker u_lcdseq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.pin_wr_valid (pin_wr_valid),
	.pin_wr_ready (pin_wr_ready),
	.pin_wr       (pin_wr)
);
